[src/rmeu_pkg.sv]
// Package for the register machine execute unit: opcode and status codes.
// No dependencies.
`default_nettype none
package rmeu_pkg;
  localparam logic [7:0] OP_TRAP   = 8'h00;
  localparam logic [7:0] OP_FCMP   = 8'h01;
  localparam logic [7:0] OP_FADD   = 8'h04;
  localparam logic [7:0] OP_FLOT   = 8'h08;
  localparam logic [7:0] OP_FDIV   = 8'h14;
  localparam logic [7:0] OP_FSQRT  = 8'h15;
  localparam logic [7:0] OP_FREM   = 8'h16;
  localparam logic [7:0] OP_MUL    = 8'h18;
  localparam logic [7:0] OP_MULU   = 8'h1A;
  localparam logic [7:0] OP_DIV    = 8'h1C;
  localparam logic [7:0] OP_DIVU   = 8'h1E;
  localparam logic [7:0] OP_ADD    = 8'h20;
  localparam logic [7:0] OP_ADDU   = 8'h22;
  localparam logic [7:0] OP_SUB    = 8'h24;
  localparam logic [7:0] OP_SUBU   = 8'h26;
  localparam logic [7:0] OP_LDB    = 8'h80;
  localparam logic [7:0] OP_LDSF   = 8'h90;
  localparam logic [7:0] OP_STB    = 8'hA0;
  localparam logic [7:0] OP_STSF   = 8'hB0;
  localparam logic [7:0] OP_OR     = 8'hC0;
  localparam logic [7:0] OP_SETH   = 8'hE0;
  localparam logic [7:0] OP_JMP    = 8'hF0;
  localparam logic [7:0] OP_PUSHJ  = 8'hF2;
  localparam logic [7:0] OP_RESUME = 8'hF9;
  localparam logic [7:0] OP_SAVE   = 8'hFA;
  localparam logic [7:0] OP_UNSAVE = 8'hFB;
  localparam logic [7:0] OP_SYNC   = 8'hFC;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DIVZ    = 2'd1;
  localparam logic [1:0] ST_UNIMPL  = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;
endpackage
`default_nettype wire

[src/rmeu_muldiv.sv]
// Shared iterative 64-bit unit: shift-add multiply (low half) and restoring divide.
// Uses no package; two result bits per cycle.
`default_nettype none
module rmeu_muldiv (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        div_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output logic             done_o,
  output logic [63:0]      res_o
);
  logic        busy_q, busy_d, div_q, div_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] a_q, a_d, b_q, b_d, acc_q, acc_d, rem_q, rem_d;
  logic [64:0] r1, r2;
  logic [63:0] q1, q2, rm1, rm2, p1, p2;

  always_comb begin
    r1  = {rem_q, a_q[63]};
    rm1 = (r1 >= {1'b0, b_q}) ? r1[63:0] - b_q : r1[63:0];
    q1  = {a_q[62:0], (r1 >= {1'b0, b_q})};
    r2  = {rm1, q1[63]};
    rm2 = (r2 >= {1'b0, b_q}) ? r2[63:0] - b_q : r2[63:0];
    q2  = {q1[62:0], (r2 >= {1'b0, b_q})};
    p1  = acc_q + (a_q[0] ? b_q : 64'd0);
    p2  = p1 + (a_q[1] ? {b_q[62:0], 1'b0} : 64'd0);
  end

  always_comb begin
    busy_d = busy_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    done_o = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      div_d  = div_i;
      cnt_d  = '0;
      a_d    = a_i;
      b_d    = b_i;
      acc_d  = '0;
      rem_d  = '0;
    end else if (busy_q) begin
      if (div_q) begin
        rem_d = rm2;
        a_d   = q2;
      end else begin
        acc_d = p2;
        a_d   = {2'b00, a_q[63:2]};
        b_d   = {b_q[61:0], 2'b00};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
    res_o = div_q ? q2 : p2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      div_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      div_q  <= div_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
  end
endmodule
`default_nettype wire

[src/register_machine_execute_unit.sv]
// Execute unit for a reduced MMIX-numbered instruction set.
// Uses rmeu_pkg and rmeu_muldiv.
//
// s_axis carries one decoded instruction per request; m_axis carries one
// result per instruction. Instructions run one at a time. Reading the two
// operand registers and register X passes through states RDY, RDZ and RDX
// before EXEC; a byte memory access adds state MEM for stores, and MEM and
// LDW for loads. Multiply and divide wait in state MD for the 32 steps of
// the shared iterative multiply/divide unit.
// After reset the block sweeps the byte memory to zero, one byte a cycle;
// the register file needs no sweep: 256 valid bits make unwritten
// registers read as zero. s_axis_tready stays low during the sweep.
// The result sits in an output register; s_axis_tready stays low until the
// receiver takes it, and a stalled result holds.
`default_nettype none
module register_machine_execute_unit
  import rmeu_pkg::*;
#(
  parameter int unsigned MEM_BYTES = 65536
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // opcode[7:0], reg_x[15:8], reg_y[23:16], reg_z[31:24]
  input  wire logic [31:0]  s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // next_pc[63:0], reg_written[64], write_index[72:65], write_value[136:73],
  // status[138:137], zero fill [143:139]
  output logic [143:0]      m_axis_tdata
);
  localparam int unsigned AW = $clog2(MEM_BYTES);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RDY, S_RDZ, S_RDX, S_EXEC, S_MEM, S_LDW, S_MD, S_OUT
  } state_e;

  state_e state_q;
  logic [7:0]  op_q, x_q, y_q, z_q;
  logic [63:0] vy_q, vz_q, pc_q;
  logic [AW-1:0] clr_q;
  logic [255:0]  vld_q;

  logic [63:0] rf_mem [256];
  logic [63:0] rf_rd_q;
  logic [7:0]  rf_ra;
  logic        rf_we;
  logic [7:0]  rf_wa;
  logic [63:0] rf_wd;
  logic        rf_vld_q;

  logic [7:0]  bm_mem [MEM_BYTES];
  logic [7:0]  bm_rd_q;
  logic [AW-1:0] bm_a;
  logic        bm_we;
  logic [7:0]  bm_wd;

  logic        md_start, md_done;
  logic [63:0] md_res;
  logic [63:0] sum_yz, rv;

  logic [63:0] npc_q;
  logic        wr_q;
  logic [7:0]  wi_q;
  logic [63:0] wv_q;
  logic [1:0]  st_q;

  assign rv     = rf_vld_q ? rf_rd_q : 64'd0;
  assign sum_yz = vy_q + vz_q;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {5'd0, st_q, wv_q, wi_q, wr_q, npc_q};

  always_comb begin
    rf_ra = y_q;
    case (state_q)
      S_RDZ:   rf_ra = z_q;
      S_RDX:   rf_ra = x_q;
      S_EXEC:  rf_ra = x_q;
      default: rf_ra = y_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) rf_mem[rf_wa] <= rf_wd;
    rf_rd_q <= rf_mem[rf_ra];
    if (bm_we) bm_mem[bm_a] <= bm_wd;
    bm_rd_q <= bm_mem[bm_a];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rf_vld_q <= 1'b0;
    else         rf_vld_q <= vld_q[rf_ra];
  end

  always_comb begin
    bm_a  = sum_yz[AW-1:0];
    bm_we = 1'b0;
    bm_wd = rv[7:0];
    if (state_q == S_CLEAR) begin
      bm_a  = clr_q;
      bm_we = 1'b1;
      bm_wd = 8'd0;
    end else if (state_q == S_MEM && op_q == OP_STB) begin
      bm_we = 1'b1;
    end
  end

  assign md_start = (state_q == S_EXEC) &&
                    (op_q == OP_MUL || op_q == OP_MULU || op_q == OP_DIV || op_q == OP_DIVU) &&
                    !((op_q == OP_DIV || op_q == OP_DIVU) && vz_q == 64'd0);

  rmeu_muldiv u_md (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .div_i   (op_q == OP_DIV || op_q == OP_DIVU),
    .a_i     (vy_q),
    .b_i     (vz_q),
    .done_o  (md_done),
    .res_o   (md_res)
  );

  always_comb begin
    rf_we = 1'b0;
    rf_wa = x_q;
    rf_wd = 64'd0;
    case (state_q)
      S_EXEC: begin
        case (op_q)
          OP_ADD, OP_ADDU: begin rf_we = 1'b1; rf_wd = sum_yz; end
          OP_SUB, OP_SUBU: begin rf_we = 1'b1; rf_wd = vy_q - vz_q; end
          OP_OR:           begin rf_we = 1'b1; rf_wd = vy_q | vz_q; end
          OP_SETH:         begin rf_we = 1'b1; rf_wd = {y_q, 56'd0} >> 8; end
          default:         rf_we = 1'b0;
        endcase
      end
      S_LDW: begin rf_we = 1'b1; rf_wd = {56'd0, bm_rd_q}; end
      S_MD:  begin rf_we = md_done; rf_wd = md_res; end
      default: rf_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      vld_q   <= '0;
      pc_q    <= 64'd0;
    end else begin
      if (rf_we) vld_q[rf_wa] <= 1'b1;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(MEM_BYTES - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op_q <= s_axis_tdata[7:0];
            x_q  <= s_axis_tdata[15:8];
            y_q  <= s_axis_tdata[23:16];
            z_q  <= s_axis_tdata[31:24];
            state_q <= S_RDY;
          end
        end
        S_RDY: state_q <= S_RDZ;
        S_RDZ: begin
          vy_q <= rv;
          state_q <= S_RDX;
        end
        S_RDX: begin
          vz_q <= rv;
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          npc_q <= pc_q + 64'd4;
          wr_q  <= 1'b0;
          wi_q  <= 8'd0;
          wv_q  <= 64'd0;
          st_q  <= ST_OK;
          state_q <= S_OUT;
          case (op_q)
            OP_ADD, OP_ADDU, OP_SUB, OP_SUBU, OP_OR, OP_SETH: begin
              wr_q <= 1'b1;
              wi_q <= x_q;
              wv_q <= rf_wd;
            end
            OP_MUL, OP_MULU: state_q <= S_MD;
            OP_DIV, OP_DIVU: begin
              if (vz_q == 64'd0) st_q <= ST_DIVZ;
              else state_q <= S_MD;
            end
            OP_LDB, OP_STB: state_q <= S_MEM;
            OP_JMP: npc_q <= rv;
            OP_TRAP, OP_FCMP, OP_FADD, OP_FLOT, OP_FDIV, OP_FSQRT, OP_FREM,
            OP_LDSF, OP_STSF, OP_PUSHJ, OP_RESUME, OP_SAVE, OP_UNSAVE,
            OP_SYNC: st_q <= ST_UNIMPL;
            default: st_q <= ST_UNKNOWN;
          endcase
        end
        S_MEM: state_q <= (op_q == OP_LDB) ? S_LDW : S_OUT;
        S_LDW: begin
          wr_q <= 1'b1;
          wi_q <= x_q;
          wv_q <= rf_wd;
          state_q <= S_OUT;
        end
        S_MD: begin
          if (md_done) begin
            wr_q <= 1'b1;
            wi_q <= x_q;
            wv_q <= md_res;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            pc_q <= npc_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[src/rmeu_checker.sv]
// Port-level checks for register_machine_execute_unit, bound to the top level.
// Uses rmeu_pkg.
`default_nettype none
module rmeu_checker
  import rmeu_pkg::*;
(
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [143:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("request taken while result pending");
  a_nowr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[64] |-> m_axis_tdata[136:65] == 72'd0)
    else $error("write fields set without a write");
  a_stw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[138:137] != ST_OK |-> !m_axis_tdata[64])
    else $error("flagged request wrote a register");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
    else $error("result appeared too early");
endmodule

bind register_machine_execute_unit rmeu_checker u_rmeu_checker (.*);
`default_nettype wire
